[rtl/core/lrcc_pkg.sv]
// shared types, codes and crc step function for the log record crc checker
`timescale 1ns / 1ps

package lrcc_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic MODE_CHECK = 1'b0;
    localparam logic MODE_BUILD = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT_HDR  = 3'd1,
        ST_SIZE_SMALL = 3'd2,
        ST_TRUNCATED  = 3'd3,
        ST_MISMATCH   = 3'd4
    } t_status;

    typedef struct packed {
        logic        opcode;
        logic [31:0] declared_size;
        logic [15:0] stored_crc;
        logic [31:0] available_bytes;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] crc_value;
        logic [31:0] record_size;
    } t_result;

    // one byte of reflected crc-16, lsb first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/lrcc_in_reg.sv]
// input register stage holding one accepted beat
`timescale 1ns / 1ps

module lrcc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lrcc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output lrcc_pkg::t_item o_item
);
    import lrcc_pkg::*;

    logic  r_valid;
    t_item r_item;

    // room when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/core/lrcc_engine.sv]
// record state, header checks and bytewise crc update
`timescale 1ns / 1ps

module lrcc_engine #(
    parameter int HEADER_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_fire,
    input  lrcc_pkg::t_item  i_item,
    output logic             o_res_valid,
    output lrcc_pkg::t_result o_res
);
    import lrcc_pkg::*;

    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    logic        r_mode;
    logic [15:0] r_crc;
    logic [31:0] r_bytes_left;
    logic [15:0] r_expected_crc;
    logic        r_in_record;
    logic [31:0] r_size_hold;

    logic [15:0] n_crc;
    logic [31:0] n_bytes_left;
    logic [15:0] n_expected_crc;
    logic        n_in_record;
    logic [31:0] n_size_hold;

    logic [32:0] total;
    logic [15:0] crc_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CHECK;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign total    = {1'b0, i_item.declared_size} + {1'b0, HDR};
    assign crc_next = crc_step(r_crc, i_item.data_byte);

    always_comb begin
        n_crc          = r_crc;
        n_bytes_left   = r_bytes_left;
        n_expected_crc = r_expected_crc;
        n_in_record    = r_in_record;
        n_size_hold    = r_size_hold;
        o_res_valid    = 1'b0;
        o_res.status   = ST_OK;
        o_res.crc_value   = 16'h0000;
        o_res.record_size = i_item.declared_size;
        if (i_item.opcode == OP_START) begin
            n_in_record = 1'b0;
            n_crc       = 16'h0000;
            if (r_mode == MODE_CHECK && i_item.available_bytes < HDR) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_SHORT_HDR;
            end else if (r_mode == MODE_CHECK && i_item.declared_size < HDR) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_SIZE_SMALL;
            end else if (r_mode == MODE_CHECK &&
                         i_item.available_bytes < i_item.declared_size) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_TRUNCATED;
            end else begin
                if (r_mode == MODE_CHECK) begin
                    n_bytes_left   = i_item.declared_size - HDR;
                    n_expected_crc = i_item.stored_crc;
                    n_size_hold    = i_item.declared_size;
                end else begin
                    n_bytes_left = i_item.declared_size;
                    n_size_hold  = total[32] ? 32'hFFFF_FFFF : total[31:0];
                end
                // empty payload closes the record on the start beat
                if (n_bytes_left == 32'd0) begin
                    o_res_valid       = 1'b1;
                    o_res.record_size = n_size_hold;
                    if (r_mode == MODE_CHECK && n_expected_crc != 16'h0000) begin
                        o_res.status = ST_MISMATCH;
                    end
                end else begin
                    n_in_record = 1'b1;
                end
            end
        end else if (r_in_record) begin
            n_crc        = crc_next;
            n_bytes_left = r_bytes_left - 32'd1;
            if (r_bytes_left == 32'd1) begin
                n_in_record       = 1'b0;
                o_res_valid       = 1'b1;
                o_res.crc_value   = crc_next;
                o_res.record_size = r_size_hold;
                if (r_mode == MODE_CHECK && crc_next != r_expected_crc) begin
                    o_res.status = ST_MISMATCH;
                end
            end
        end
        o_res_valid = o_res_valid && i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc          <= 16'h0000;
            r_bytes_left   <= 32'd0;
            r_expected_crc <= 16'h0000;
            r_in_record    <= 1'b0;
            r_size_hold    <= 32'd0;
        end else if (i_fire) begin
            r_crc          <= n_crc;
            r_bytes_left   <= n_bytes_left;
            r_expected_crc <= n_expected_crc;
            r_in_record    <= n_in_record;
            r_size_hold    <= n_size_hold;
        end
    end

endmodule

[rtl/core/lrcc_out_reg.sv]
// result register toward the master side
`timescale 1ns / 1ps

module lrcc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lrcc_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_tready,
    output lrcc_pkg::t_result o_res
);
    import lrcc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_tready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/core/log_record_crc_checker_core.sv]
// top level of the log record crc-16/arc checker and builder
`timescale 1ns / 1ps

// Checks or builds log records with a CRC-16/ARC (reflected poly 0xA001, init 0)
// over the payload, one byte per beat. A start beat (tuser = 0) carries the
// parsed header fields; payload beats (tuser = 1) carry one byte each. In check
// mode a bad header gives an immediate error result, otherwise the last payload
// byte gives a result comparing the computed and stored CRC. In build mode the
// last byte reports the CRC and the header-plus-payload size, saturated at
// 0xFFFFFFFF; an empty payload reports on its start beat instead. Payload beats
// outside a record are dropped silently. The block takes one beat every cycle
// while the result register has room; a beat passes the input register, the
// combinational crc byte update, then the result register. The mode register is
// written by i_cfg_we / i_cfg_wdata and must only change while no record is open.

module log_record_crc_checker_core #(
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] declared_size, [47:32] stored_crc, [79:48] available_bytes,
    // [87:80] data_byte
    input  logic [87:0] i_s_axis_tdata,
    // [0] opcode
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] status, [18:3] crc_value, [50:19] record_size, [55:51] zero
    output logic [55:0] o_m_axis_tdata
);
    import lrcc_pkg::*;

    t_item   s_item;
    t_item   q_item;
    t_result e_res;
    t_result m_res;
    logic    q_valid;
    logic    e_valid;
    logic    out_ready;
    logic    fire;

    // unpack slave beat
    assign s_item.opcode          = i_s_axis_tuser;
    assign s_item.declared_size   = i_s_axis_tdata[31:0];
    assign s_item.stored_crc      = i_s_axis_tdata[47:32];
    assign s_item.available_bytes = i_s_axis_tdata[79:48];
    assign s_item.data_byte       = i_s_axis_tdata[87:80];

    // held beat is processed whenever the result register has room
    assign fire = q_valid && out_ready;

    lrcc_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (s_item),
        .o_valid (q_valid),
        .i_take  (fire),
        .o_item  (q_item)
    );

    lrcc_engine #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (q_item),
        .o_res_valid (e_valid),
        .o_res       (e_res)
    );

    lrcc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (e_valid),
        .i_res    (e_res),
        .o_ready  (out_ready),
        .o_valid  (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_res    (m_res)
    );

    // pack master beat
    assign o_m_axis_tdata = {5'b00000, m_res.record_size, m_res.crc_value, m_res.status};

    // an empty result register never blocks the slave side
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("slave side stalled with empty result register");

    // results only come from a processed beat
    a_result_from_fire : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_valid |-> fire)
        else $error("result produced without a processed beat");

    // closed records always cover at least a header
    a_closed_size : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (m_res.status == ST_OK || m_res.status == ST_MISMATCH))
        |-> (m_res.record_size >= 32'(HEADER_BYTES)))
        else $error("closed record smaller than header");

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the log record crc-16/arc checker core
`timescale 1ns / 1ps

module testbench;

    import lrcc_pkg::*;

    localparam int HDR_BYTES = 16;
    // cycles with no accepted beat and no register write before the run is given up
    localparam int STALL_LIMIT = 2000;

    // keeps its own copy of the block state and the awaited result beats
    class record_crc_scoreboard;
        logic        mode;
        logic [15:0] crc_acc;
        logic [31:0] bytes_left;
        logic [15:0] header_crc;
        logic        open;
        logic [31:0] size_hold;
        int unsigned hdr_bytes;
        t_result     awaited_results[$];
        int          errors;
        int          results_seen;

        function new(int unsigned hdr);
            hdr_bytes  = hdr;
            mode       = MODE_CHECK;
            crc_acc    = '0;
            bytes_left = '0;
            header_crc = '0;
            open       = 1'b0;
            size_hold  = '0;
            errors     = 0;
            results_seen = 0;
        endfunction

        // reflected crc-16, one data bit per step, lsb first
        function logic [15:0] crc16_arc_byte(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function void await_result(t_status st, logic [15:0] crc, logic [31:0] size);
            t_result r;
            r.status      = st;
            r.crc_value   = crc;
            r.record_size = size;
            awaited_results.push_back(r);
        endfunction

        // last payload byte or empty payload: compare in check mode, report in build mode
        function void close_record();
            open = 1'b0;
            if (mode == MODE_CHECK && crc_acc != header_crc) begin
                await_result(ST_MISMATCH, crc_acc, size_hold);
            end else begin
                await_result(ST_OK, crc_acc, size_hold);
            end
        endfunction

        // returns 0 when the beat is a stray payload byte that the block drops
        function bit note_beat(t_item it);
            logic [32:0] total;
            if (it.opcode == OP_START) begin
                open    = 1'b0;
                crc_acc = '0;
                if (mode == MODE_CHECK) begin
                    if (it.available_bytes < hdr_bytes) begin
                        await_result(ST_SHORT_HDR, 16'h0, it.declared_size);
                        return 1'b1;
                    end
                    if (it.declared_size < hdr_bytes) begin
                        await_result(ST_SIZE_SMALL, 16'h0, it.declared_size);
                        return 1'b1;
                    end
                    if (it.available_bytes < it.declared_size) begin
                        await_result(ST_TRUNCATED, 16'h0, it.declared_size);
                        return 1'b1;
                    end
                    bytes_left = it.declared_size - hdr_bytes;
                    header_crc = it.stored_crc;
                    size_hold  = it.declared_size;
                end else begin
                    total      = {1'b0, it.declared_size} + hdr_bytes;
                    size_hold  = total[32] ? 32'hFFFF_FFFF : total[31:0];
                    bytes_left = it.declared_size;
                end
                if (bytes_left == 0) begin
                    close_record();
                end else begin
                    open = 1'b1;
                end
                return 1'b1;
            end
            if (!open) begin
                return 1'b0;
            end
            crc_acc    = crc16_arc_byte(crc_acc, it.data_byte);
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) begin
                close_record();
            end
            return 1'b1;
        endfunction

        function void check_result(logic [55:0] beat);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("result beat %h with no result awaited", beat);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            results_seen++;
            if (beat[2:0] !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, beat[2:0]);
                errors++;
            end
            if (beat[18:3] !== want.crc_value) begin
                $error("crc_value: expected %h, actual %h", want.crc_value, beat[18:3]);
                errors++;
            end
            if (beat[50:19] !== want.record_size) begin
                $error("record_size: expected %h, actual %h", want.record_size, beat[50:19]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [31:0] declared_size, [47:32] stored_crc, [79:48] available_bytes,
    // [87:80] data_byte
    logic [87:0] i_s_axis_tdata = '0;
    // [0] opcode
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [2:0] status, [18:3] crc_value, [50:19] record_size, [55:51] zero
    logic [55:0] o_m_axis_tdata;

    record_crc_scoreboard sb = new(HDR_BYTES);

    logic cur_mode = MODE_CHECK;
    // while set, the matching side runs without gaps or stalls
    bit   calm_in = 1'b0;
    bit   calm_out = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   beats_used = 0;
    int   records_sent = 0;
    int   mode_writes = 0;

    log_record_crc_checker_core #(
        .HEADER_BYTES(HDR_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // mostly short idle stretches, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 40);
    endfunction

    // result side: random stalls unless in a calm stretch
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (!calm_out && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
            end
        end
    end

    // result beats are checked as they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
    end

    // watchdog: any accepted beat or register write counts as progress
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without progress", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // every field random, opcode as given
    function automatic t_item random_item(logic op);
        t_item it;
        it.opcode          = op;
        it.declared_size   = $urandom;
        it.stored_crc      = 16'($urandom);
        it.available_bytes = $urandom;
        it.data_byte       = 8'($urandom);
        return it;
    endfunction

    // called and returns at a falling edge; valid is left high for a back-to-back beat
    task automatic send_beat(input t_item it);
        int gap;
        gap = 0;
        if (!calm_in && $urandom_range(0, 99) >= 55) begin
            gap = gap_len();
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.data_byte, it.available_bytes, it.stored_crc, it.declared_size};
        i_s_axis_tuser  <= it.opcode;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        if (sb.note_beat(it)) begin
            beats_used++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_start(input logic [31:0] dsize, input logic [15:0] scrc,
                              input logic [31:0] avail);
        t_item it;
        it = random_item(OP_START);
        it.declared_size   = dsize;
        it.stored_crc      = scrc;
        it.available_bytes = avail;
        send_beat(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_item it;
        it = random_item(OP_BYTE);
        it.data_byte = b;
        send_beat(it);
    endtask

    // start beat sized for n payload bytes, then the first n_sent of them;
    // a short count leaves the record open for the next start to abandon
    task automatic send_record(input int unsigned n, input int unsigned n_sent,
                               input bit good_crc);
        logic [7:0]  payload[$];
        logic [15:0] crc;
        logic [31:0] dsize;
        logic [31:0] avail;
        logic [15:0] scrc;
        crc = '0;
        for (int i = 0; i < n; i++) begin
            payload.push_back(8'($urandom));
            crc = sb.crc16_arc_byte(crc, payload[i]);
        end
        dsize = (cur_mode == MODE_CHECK) ? n + HDR_BYTES : n;
        avail = $urandom;
        if ($urandom_range(0, 3) == 0 || avail < dsize) begin
            avail = dsize;
        end
        scrc = good_crc ? crc : 16'($urandom);
        send_start(dsize, scrc, avail);
        for (int i = 0; i < n_sent; i++) begin
            send_byte(payload[i]);
        end
        records_sent++;
    endtask

    // close any open record with an immediate result, then drain and let the pipe empty
    task automatic settle();
        send_start(32'd0, 16'($urandom), 32'd0);
        i_s_axis_tvalid <= 1'b0;
        while (sb.awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        sb.set_mode(m);
        cur_mode = m;
        mode_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one random record shape, weighted toward well-formed records
    task automatic random_record();
        int          pick;
        int unsigned n;
        logic [31:0] dsize;
        if ($urandom_range(0, 19) == 0) begin
            calm_in = !calm_in;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_out = !calm_out;
        end
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48) : $urandom_range(0, 10);
        if (pick < 65) begin
            send_record(n, n, $urandom_range(0, 99) < 80);
        end else if (pick < 80) begin
            if (cur_mode == MODE_CHECK) begin
                case ($urandom_range(0, 2))
                    0: begin
                        send_start($urandom, 16'($urandom),
                                   $urandom_range(0, HDR_BYTES - 1));
                    end
                    1: begin
                        send_start($urandom_range(0, HDR_BYTES - 1), 16'($urandom),
                                   $urandom | 32'h10);
                    end
                    default: begin
                        dsize = $urandom | 32'h100;
                        send_start(dsize, 16'($urandom),
                                   $urandom_range(HDR_BYTES, dsize - 1));
                    end
                endcase
            end else begin
                // huge payload count: the record stays open and gets abandoned
                send_start($urandom | 32'h8000_0000, 16'($urandom), $urandom);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end
            records_sent++;
        end else if (pick < 90) begin
            n = n + 2;
            send_record(n, $urandom_range(0, n - 1), 1'b1);
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else begin
            send_beat(random_item(1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        logic [15:0] crc;
        logic        phase_modes[6];
        int          target;
        phase_modes = '{MODE_BUILD, MODE_CHECK, MODE_BUILD, MODE_CHECK, MODE_CHECK, MODE_BUILD};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, check mode: stray bytes, each header fault at its edges,
        // empty payloads, a good record, an abandoned record, a crc mismatch
        write_mode(MODE_CHECK);
        send_byte(8'h00);
        send_start(32'd0, 16'h0000, 32'd15);
        send_start(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        send_start(32'd15, 16'h0000, 32'hFFFF_FFFF);
        send_start(32'd0, 16'hFFFF, 32'd16);
        send_start(32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFE);
        send_start(32'd17, 16'hFFFF, 32'd16);
        send_start(32'd16, 16'h0000, 32'd16);
        send_start(32'd16, 16'hFFFF, 32'd16);
        crc = sb.crc16_arc_byte(sb.crc16_arc_byte(16'h0, 8'h00), 8'hFF);
        send_start(32'd18, crc, 32'd18);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_start(32'd20, 16'h1234, 32'hFFFF_FFFF);
        send_byte(8'h80);
        crc = sb.crc16_arc_byte(16'h0, 8'h01);
        send_start(32'd17, ~crc, 32'd17);
        send_byte(8'h01);
        settle();

        // directed, build mode: empty payload, sizes at the top of the range
        write_mode(MODE_BUILD);
        send_start(32'd0, 16'($urandom), $urandom);
        send_start(32'hFFFF_FFFF, 16'($urandom), $urandom);
        send_byte(8'hFF);
        send_start(32'hFFFF_FFEF, 16'($urandom), $urandom);
        send_byte(8'h00);
        send_start(32'd2, 16'($urandom), $urandom);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        settle();

        target = beats_used;
        foreach (phase_modes[p]) begin
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            write_mode(phase_modes[p]);
            target = target + 235;
            while (beats_used < target) begin
                random_record();
            end
            settle();
        end

        repeat (8) @(negedge i_clk);
        if (sb.awaited_results.size() != 0) begin
            $error("%0d results never arrived", sb.awaited_results.size());
            sb.errors++;
        end
        $display("coverage: %0d beats used, %0d records, %0d mode writes",
                 beats_used, records_sent, mode_writes);
        $display("checked %0d result beats, %0d mismatches", sb.results_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/lrcc_pkg.sv
rtl/core/lrcc_in_reg.sv
rtl/core/lrcc_engine.sv
rtl/core/lrcc_out_reg.sv
rtl/core/log_record_crc_checker_core.sv
tb/sv/testbench.sv
